### hw/rtl/tmsg_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the text mode scanline generator
// no dependencies; used by the interfaces, the divider and the top level

package tmsg_pkg;

  // defaults for the top level parameters
  localparam int VRAM_DEPTH_DEF    = 8192;
  localparam int LINES_PER_ROW_DEF = 10;

  // font store: eight bytes per character, 128 characters
  localparam int FONT_DEPTH = 1024;
  localparam int FONT_AW    = 10;
  localparam int GLYPH_ROWS = 8;

  // field widths
  localparam int ADDR_W     = 13;
  localparam int WORD_W     = 16;
  localparam int STRIDE_W   = 7;
  localparam int QUO_W      = 8;
  localparam int COLS_MAX   = 64;
  localparam int ROWS_MAX   = 32;

  // opcodes
  localparam logic [1:0] OP_VRAM_WR = 2'd0;
  localparam logic [1:0] OP_FONT_WR = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  // register indexes on the apb port
  localparam logic [2:0] REG_COLUMNS_SHOWN   = 3'd0;
  localparam logic [2:0] REG_ROW_STRIDE      = 3'd1;
  localparam logic [2:0] REG_ROWS_SHOWN      = 3'd2;
  localparam logic [2:0] REG_SCREEN_BASE     = 3'd3;
  localparam logic [2:0] REG_CURSOR_LOCATION = 3'd4;
  localparam logic [2:0] REG_CURSOR_BIAS     = 3'd5;
  localparam logic [2:0] REG_SCROLL_ENABLE   = 3'd6;

  // register reset values
  localparam logic [6:0]  COLUMNS_SHOWN_RST   = 7'd28;
  localparam logic [6:0]  ROW_STRIDE_RST      = 7'd28;
  localparam logic [5:0]  ROWS_SHOWN_RST      = 6'd12;
  localparam logic [12:0] SCREEN_BASE_RST     = 13'd0;
  localparam logic [12:0] CURSOR_LOCATION_RST = 13'd122;
  localparam logic [15:0] CURSOR_BIAS_RST     = 16'h3c80;

  // input beat
  typedef struct packed {
    logic [1:0]  opcode;
    logic [12:0] address;
    logic [7:0]  data;
  } in_beat_t;

  // output beat
  typedef struct packed {
    logic [7:0] pixels;
    logic [5:0] column;
    logic [8:0] scanline;
    logic       line_end;
    logic       frame_end;
  } out_beat_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hw/rtl/tmsg_if.sv
`timescale 1ns / 1ps
// valid/ready channels of the text mode scanline generator
// depends on tmsg_pkg for the beat types

interface tmsg_in_if;
  logic               valid;
  logic               ready;
  tmsg_pkg::in_beat_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tmsg_out_if;
  logic                valid;
  logic                ready;
  tmsg_pkg::out_beat_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/tmsg_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, for the scroll origin
// depends on tmsg_pkg for widths and the status struct

module tmsg_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [tmsg_pkg::WORD_W-1:0]     dividend,
  input  logic [tmsg_pkg::STRIDE_W-1:0]   divisor,
  output tmsg_pkg::div_stat_t             stat,
  output logic [tmsg_pkg::WORD_W-1:0]     quotient
);

  localparam int CW = $clog2(tmsg_pkg::WORD_W);

  logic [tmsg_pkg::STRIDE_W-1:0] rem;
  logic [tmsg_pkg::WORD_W-1:0]   quo;
  logic [CW-1:0]                 cnt;
  logic                          busy;
  logic                          done;
  logic [tmsg_pkg::STRIDE_W:0]   trial;
  logic                          fits;

  // shift in the next dividend bit and try the subtraction
  assign trial = {rem, quo[tmsg_pkg::WORD_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // done pulses for one cycle after the last quotient bit
      done <= busy && !start && (cnt == CW'(tmsg_pkg::WORD_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        if (fits) begin
          rem <= tmsg_pkg::STRIDE_W'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[tmsg_pkg::STRIDE_W-1:0];
        end
        quo <= {quo[tmsg_pkg::WORD_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(tmsg_pkg::WORD_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

### hw/rtl/text_mode_scanline_generator.sv
`timescale 1ns / 1ps
// top level of the text mode scanline generator: raster sequencer, video and font memories
// depends on tmsg_pkg, tmsg_if and tmsg_div

// Write beats fill the video memory and the font memory.
// A tick beat emits the next eight-pixel group of the raster. A glyph line goes from
// accept through a video read and a font read to emit into the output register; a
// blank line reads neither memory. Both memories are read synchronously.
// The first tick of a frame with scrolling enabled first reads the cursor word in two
// reads and runs a restoring divide by the row stride. The next beat is taken
// as soon as a result sits in the output register, even while it waits for the sink.
// VRAM_DEPTH must be a power of two; addresses wrap modulo that depth.

module text_mode_scanline_generator #(
  parameter int VRAM_DEPTH    = tmsg_pkg::VRAM_DEPTH_DEF,
  parameter int LINES_PER_ROW = tmsg_pkg::LINES_PER_ROW_DEF
) (
  input  logic        clk,
  input  logic        rst,
  tmsg_in_if.sink     in_ch,
  tmsg_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int VAW = $clog2(VRAM_DEPTH);
  localparam int LW  = $clog2(LINES_PER_ROW);

  typedef logic [VAW-1:0] vaddr_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CUR_LO,
    S_CUR_HI,
    S_CUR_CALC,
    S_DIV,
    S_ORIGIN,
    S_LINE,
    S_CHAR,
    S_EMIT
  } state_t;

  // configuration registers
  logic [6:0]  columns_shown;
  logic [6:0]  row_stride;
  logic [5:0]  rows_shown;
  logic [12:0] screen_base;
  logic [12:0] cursor_location;
  logic [15:0] cursor_bias;
  logic        scroll_enable;

  // memories
  logic [7:0] vram [VRAM_DEPTH];
  logic [7:0] font [tmsg_pkg::FONT_DEPTH];
  logic [7:0] vram_q;
  logic [7:0] font_q;
  logic       vram_re;
  vaddr_t     vram_raddr;
  logic       font_re;
  logic [tmsg_pkg::FONT_AW-1:0] font_raddr;

  // sequencer state
  state_t      state;
  logic [4:0]  row_counter;
  logic [LW-1:0] line_in_row;
  logic [5:0]  column_counter;
  logic [15:0] row_start;
  logic [7:0]  cur_lo;
  logic        blank;
  logic        out_valid;
  tmsg_pkg::out_beat_t out_beat;

  // divider
  tmsg_pkg::div_stat_t div_stat;
  logic [15:0] div_quo;
  logic [15:0] cursor_rel;
  logic        div_start;

  // combinational helpers
  logic        in_acc;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  logic        out_free;
  logic        out_load;
  logic        frame_start;
  logic        glyph_line;
  logic [6:0]  cols_eff;
  logic [5:0]  rows_eff;
  logic [4:0]  rows_last;
  logic        lend;
  logic        line_last;
  logic        row_last;
  logic        fend;
  logic [7:0]  quo8;
  logic [7:0]  quo_diff;
  logic [14:0] origin_prod;
  logic [15:0] origin;
  logic [8:0]  scan_now;
  logic [16:0] cur_hi_addr;
  logic [16:0] char_addr;

  // apb register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      columns_shown   <= tmsg_pkg::COLUMNS_SHOWN_RST;
      row_stride      <= tmsg_pkg::ROW_STRIDE_RST;
      rows_shown      <= tmsg_pkg::ROWS_SHOWN_RST;
      screen_base     <= tmsg_pkg::SCREEN_BASE_RST;
      cursor_location <= tmsg_pkg::CURSOR_LOCATION_RST;
      cursor_bias     <= tmsg_pkg::CURSOR_BIAS_RST;
      scroll_enable   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tmsg_pkg::REG_COLUMNS_SHOWN:   columns_shown   <= pwdata[6:0];
        tmsg_pkg::REG_ROW_STRIDE:      row_stride      <= pwdata[6:0];
        tmsg_pkg::REG_ROWS_SHOWN:      rows_shown      <= pwdata[5:0];
        tmsg_pkg::REG_SCREEN_BASE:     screen_base     <= pwdata[12:0];
        tmsg_pkg::REG_CURSOR_LOCATION: cursor_location <= pwdata[12:0];
        tmsg_pkg::REG_CURSOR_BIAS:     cursor_bias     <= pwdata[15:0];
        tmsg_pkg::REG_SCROLL_ENABLE:   scroll_enable   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_idx)
      tmsg_pkg::REG_COLUMNS_SHOWN:   prdata = 32'(columns_shown);
      tmsg_pkg::REG_ROW_STRIDE:      prdata = 32'(row_stride);
      tmsg_pkg::REG_ROWS_SHOWN:      prdata = 32'(rows_shown);
      tmsg_pkg::REG_SCREEN_BASE:     prdata = 32'(screen_base);
      tmsg_pkg::REG_CURSOR_LOCATION: prdata = 32'(cursor_location);
      tmsg_pkg::REG_CURSOR_BIAS:     prdata = 32'(cursor_bias);
      tmsg_pkg::REG_SCROLL_ENABLE:   prdata = 32'(scroll_enable);
      default:                       prdata = '0;
    endcase
  end

  // channel handshakes
  assign in_ch.ready    = (state == S_IDLE);
  assign in_acc         = in_ch.valid && in_ch.ready;
  assign out_free       = !out_valid || out_ch.ready;
  assign out_load       = (state == S_EMIT) && out_free;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_beat;

  // clamped sizes and end-of-group flags
  always_comb begin
    if (columns_shown == 7'd0) begin
      cols_eff = 7'd1;
    end else if (columns_shown > 7'(tmsg_pkg::COLS_MAX)) begin
      cols_eff = 7'(tmsg_pkg::COLS_MAX);
    end else begin
      cols_eff = columns_shown;
    end
    if (rows_shown == 6'd0) begin
      rows_eff = 6'd1;
    end else if (rows_shown > 6'(tmsg_pkg::ROWS_MAX)) begin
      rows_eff = 6'(tmsg_pkg::ROWS_MAX);
    end else begin
      rows_eff = rows_shown;
    end
  end

  assign rows_last   = 5'(rows_eff - 6'd1);
  assign lend        = ({1'b0, column_counter} + 7'd1) >= cols_eff;
  assign line_last   = ({1'b0, line_in_row} + 1'b1) >= (LW + 1)'(LINES_PER_ROW);
  assign row_last    = ({1'b0, row_counter} + 6'd1) >= rows_eff;
  assign fend        = lend && line_last && row_last;
  assign frame_start = (row_counter == '0) && (line_in_row == '0) && (column_counter == '0);
  assign glyph_line  = line_in_row < LW'(tmsg_pkg::GLYPH_ROWS);
  assign scan_now    = 9'(row_counter) * 9'(LINES_PER_ROW) + 9'(line_in_row);

  // scroll origin from the divided cursor offset
  assign cursor_rel  = {vram_q, cur_lo} - cursor_bias;
  assign div_start   = (state == S_CUR_CALC);
  assign quo8        = (row_stride == 7'd0) ? 8'd0 : div_quo[7:0];
  assign quo_diff    = quo8 - 8'(rows_last);
  assign origin_prod = 15'(quo_diff) * 15'(row_stride);
  assign origin      = (quo8 > 8'(rows_last)) ? 16'(origin_prod) + 16'(screen_base)
                                              : 16'(screen_base);

  tmsg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cursor_rel),
    .divisor  (row_stride),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // video memory read address per state
  assign cur_hi_addr = 17'(cursor_location) + 17'd1;
  assign char_addr   = 17'(row_start) + 17'(column_counter);

  always_comb begin
    vram_re    = 1'b0;
    vram_raddr = vaddr_t'(cursor_location);
    case (state)
      S_CUR_LO: begin
        vram_re    = 1'b1;
        vram_raddr = vaddr_t'(cursor_location);
      end
      S_CUR_HI: begin
        vram_re    = 1'b1;
        vram_raddr = vaddr_t'(cur_hi_addr);
      end
      S_LINE: begin
        vram_re    = glyph_line;
        vram_raddr = vaddr_t'(char_addr);
      end
      default: ;
    endcase
  end

  // font row of the character just read
  assign font_re    = (state == S_CHAR);
  assign font_raddr = {vram_q[6:0], line_in_row[2:0] + 3'd1};

  // video memory
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.payload.opcode == tmsg_pkg::OP_VRAM_WR) begin
      vram[vaddr_t'(in_ch.payload.address)] <= in_ch.payload.data;
    end
    if (vram_re) begin
      vram_q <= vram[vram_raddr];
    end
  end

  // font memory
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.payload.opcode == tmsg_pkg::OP_FONT_WR) begin
      font[in_ch.payload.address[tmsg_pkg::FONT_AW-1:0]] <= in_ch.payload.data;
    end
    if (font_re) begin
      font_q <= font[font_raddr];
    end
  end

  // sequencer, raster counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      row_counter    <= '0;
      line_in_row    <= '0;
      column_counter <= '0;
      row_start      <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc && in_ch.payload.opcode == tmsg_pkg::OP_TICK) begin
            if (frame_start && scroll_enable) begin
              state <= S_CUR_LO;
            end else begin
              if (frame_start) begin
                row_start <= 16'(screen_base);
              end
              state <= S_LINE;
            end
          end
        end
        S_CUR_LO: state <= S_CUR_HI;
        S_CUR_HI: begin
          cur_lo <= vram_q;
          state  <= S_CUR_CALC;
        end
        S_CUR_CALC: state <= S_DIV;
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_ORIGIN;
          end
        end
        S_ORIGIN: begin
          row_start <= origin;
          state     <= S_LINE;
        end
        S_LINE: begin
          blank <= !glyph_line;
          state <= glyph_line ? S_CHAR : S_EMIT;
        end
        S_CHAR: state <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            out_valid          <= 1'b1;
            out_beat.pixels    <= blank ? 8'hff : ~font_q;
            out_beat.column    <= column_counter;
            out_beat.scanline  <= scan_now;
            out_beat.line_end  <= lend;
            out_beat.frame_end <= fend;
            if (!lend) begin
              column_counter <= column_counter + 6'd1;
            end else begin
              column_counter <= '0;
              if (!line_last) begin
                line_in_row <= line_in_row + 1'b1;
              end else begin
                line_in_row <= '0;
                row_start   <= row_start + 16'(row_stride);
                row_counter <= row_last ? 5'd0 : row_counter + 5'd1;
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_line_range: assert property (@(posedge clk) disable iff (rst)
    32'(line_in_row) < LINES_PER_ROW)
    else $error("line counter past the row height");

  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> state == S_DIV)
    else $error("divider running outside the divide step");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    out_load && fend |=> row_counter == '0 && line_in_row == '0 && column_counter == '0)
    else $error("raster counters not cleared after the last group of a frame");

  a_blank_pixels: assert property (@(posedge clk) disable iff (rst)
    out_load && blank |=> out_beat.pixels == 8'hff)
    else $error("blank line emitted lit pixels");

endmodule

### tb/tb_text_mode_scanline_generator.sv
`timescale 1ns / 1ps
// self-checking bench for the text mode scanline generator: preload, directed table, random phases
// depends on tmsg_pkg, tmsg_if and the text_mode_scanline_generator rtl

module tb_text_mode_scanline_generator;
  import tmsg_pkg::*;

  localparam int VRAM_DEPTH    = VRAM_DEPTH_DEF;
  localparam int LINES_PER_ROW = LINES_PER_ROW_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 250;
  localparam int PHASE_ITEMS   = 30;
  localparam int MAX_PRINTS    = 30;

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tmsg_in_if  in_ch ();
  tmsg_out_if out_ch ();

  text_mode_scanline_generator uut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // mirror of the memories, raster counters and registers
  logic [7:0]  vram_copy [VRAM_DEPTH];
  logic [7:0]  font_copy [FONT_DEPTH];
  int unsigned row_cnt, line_cnt, col_cnt, row_base;
  int unsigned cfg_cols   = COLUMNS_SHOWN_RST;
  int unsigned cfg_stride = ROW_STRIDE_RST;
  int unsigned cfg_rows   = ROWS_SHOWN_RST;
  int unsigned cfg_base   = SCREEN_BASE_RST;
  int unsigned cfg_cursor = CURSOR_LOCATION_RST;
  int unsigned cfg_bias   = CURSOR_BIAS_RST;
  int unsigned cfg_scroll = 0;

  out_beat_t pending_groups [$];

  bit hold_req    = 1'b0;
  bit sink_quiet  = 1'b1;
  bit src_idle_on = 1'b0;
  int mismatch_count, n_ticks, n_writes, n_ignored, n_checked, n_frames, n_settings;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // next pixel group of the raster, or a memory write
  function automatic bit predict_group(input in_beat_t b, output out_beat_t g);
    int unsigned cols, rows, glyph, chr, word, q, t;
    bit lend, fend;
    g = '0;
    case (b.opcode)
      OP_VRAM_WR: begin
        vram_copy[b.address % VRAM_DEPTH] = b.data;
        return 1'b0;
      end
      OP_FONT_WR: begin
        font_copy[b.address % FONT_DEPTH] = b.data;
        return 1'b0;
      end
      OP_TICK: ;
      default: return 1'b0;
    endcase

    cols = (cfg_cols == 0) ? 1 : (cfg_cols > COLS_MAX ? COLS_MAX : cfg_cols);
    rows = (cfg_rows == 0) ? 1 : (cfg_rows > ROWS_MAX ? ROWS_MAX : cfg_rows);

    // frame start: pick the first row, following the cursor when scrolling
    if (row_cnt == 0 && line_cnt == 0 && col_cnt == 0) begin
      row_base = cfg_base;
      if (cfg_scroll != 0) begin
        word = {vram_copy[(cfg_cursor + 1) % VRAM_DEPTH], vram_copy[cfg_cursor % VRAM_DEPTH]};
        word = (word - cfg_bias) & 16'hffff;
        q = (cfg_stride != 0) ? (word / cfg_stride) & 8'hff : 0;
        t = rows - 1;
        if (q > t) row_base = ((q - t) * cfg_stride + cfg_base) & 16'hffff;
      end
    end

    if (line_cnt < GLYPH_ROWS) begin
      chr = vram_copy[(row_base + col_cnt) % VRAM_DEPTH] & 7'h7f;
      glyph = font_copy[((chr << 3) | ((line_cnt + 1) & 7)) % FONT_DEPTH];
    end else begin
      glyph = 0;
    end

    lend = (col_cnt + 1 >= cols);
    fend = lend && (line_cnt + 1 >= LINES_PER_ROW) && (row_cnt + 1 >= rows);

    g.pixels    = 8'(~glyph);
    g.column    = 6'(col_cnt);
    g.scanline  = 9'(row_cnt * LINES_PER_ROW + line_cnt);
    g.line_end  = lend;
    g.frame_end = fend;

    // advance column, line and row
    if (!lend) begin
      col_cnt++;
    end else begin
      col_cnt = 0;
      if (line_cnt + 1 < LINES_PER_ROW) begin
        line_cnt++;
      end else begin
        line_cnt = 0;
        row_base = (row_base + cfg_stride) & 16'hffff;
        row_cnt = (row_cnt + 1 < rows) ? row_cnt + 1 : 0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void cfg_apply(input logic [2:0] idx, input int unsigned val);
    case (idx)
      REG_COLUMNS_SHOWN:   cfg_cols   = val & 7'h7f;
      REG_ROW_STRIDE:      cfg_stride = val & 7'h7f;
      REG_ROWS_SHOWN:      cfg_rows   = val & 6'h3f;
      REG_SCREEN_BASE:     cfg_base   = val & 13'h1fff;
      REG_CURSOR_LOCATION: cfg_cursor = val & 13'h1fff;
      REG_CURSOR_BIAS:     cfg_bias   = val & 16'hffff;
      REG_SCROLL_ENABLE:   cfg_scroll = val & 1;
      default: ;
    endcase
  endfunction

  function automatic dir_row_t mk_row(input logic [1:0] op, input logic [12:0] a,
                                      input logic [7:0] d, input bit typed = 1'b0,
                                      input logic [7:0] px = '0, input logic [5:0] col = '0);
    dir_row_t r;
    r.beat.opcode  = op;
    r.beat.address = a;
    r.beat.data    = d;
    r.typed        = typed;
    r.want         = '0;
    r.want.pixels  = px;
    r.want.column  = col;
    return r;
  endfunction

  // mostly ticks, writes biased toward the shown row and the cursor word
  function automatic in_beat_t rand_item();
    in_beat_t b;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    b.address = 13'($urandom);
    b.data = 8'($urandom);
    if (pick < 65) begin
      b.opcode = OP_TICK;
    end else if (pick < 85) begin
      b.opcode = OP_VRAM_WR;
      case ($urandom_range(0, 3))
        0: b.address = 13'(row_base + $urandom_range(0, 63));
        1: b.address = 13'(cfg_cursor + $urandom_range(0, 1));
        default: ;
      endcase
    end else if (pick < 97) begin
      b.opcode = OP_FONT_WR;
    end else begin
      b.opcode = OP_UNUSED;
    end
    return b;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) $display("[%0t] raster check failed: %s", $time, msg);
  endtask

  // offer one beat, predict on accept
  task automatic send_beat(input in_beat_t b, input bit typed = 1'b0,
                           input out_beat_t want = '0);
    out_beat_t g;
    in_ch.valid   <= 1'b1;
    in_ch.payload <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (predict_group(b, g)) begin
      pending_groups.push_back(typed ? want : g);
      n_ticks++;
    end else if (b.opcode == OP_UNUSED) begin
      n_ignored++;
    end else begin
      n_writes++;
    end
  endtask

  // quiet the input, let every group drain, then cover the block's own latency
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (pending_groups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] idx, input int unsigned val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_apply(idx, val);
    @(posedge clk);
  endtask

  // all registers, then, when scrolling is on, a cursor word placed near the scroll threshold
  task automatic configure(input int unsigned cols, input int unsigned stride,
                           input int unsigned rows, input int unsigned base,
                           input int unsigned cursor, input int unsigned bias,
                           input int unsigned scroll);
    int unsigned w;
    in_beat_t b;
    apb_write(REG_COLUMNS_SHOWN, cols);
    apb_write(REG_ROW_STRIDE, stride);
    apb_write(REG_ROWS_SHOWN, rows);
    apb_write(REG_SCREEN_BASE, base);
    apb_write(REG_CURSOR_LOCATION, cursor);
    apb_write(REG_CURSOR_BIAS, bias);
    apb_write(REG_SCROLL_ENABLE, scroll);
    n_settings++;
    if (cfg_scroll != 0) begin
      w = (cfg_bias + $urandom_range(0, cfg_stride * (cfg_rows + 3) + 1)) & 16'hffff;
      b.opcode = OP_VRAM_WR;
      b.address = 13'(cfg_cursor);
      b.data = w[7:0];
      send_beat(b);
      b.address = 13'(cfg_cursor + 1);
      b.data = w[15:8];
      send_beat(b);
    end
  endtask

  task automatic run_phase(input int n);
    int done_items;
    in_beat_t b;
    done_items = 0;
    while (done_items < n) begin
      b = rand_item();
      send_beat(b);
      if (b.opcode != OP_UNUSED) done_items++;
      if (src_idle_on && $urandom_range(0, 3) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    settle_block();
  endtask

  // sink side: random stall bursts, one long hold-off on request
  initial begin : sink
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!sink_quiet && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // compare each output beat with the oldest predicted group
  always @(posedge clk) begin
    out_beat_t got, want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = out_ch.payload;
      if (pending_groups.size() == 0) begin
        flag_mismatch($sformatf("group %h with nothing pending", got));
      end else begin
        want = pending_groups.pop_front();
        n_checked++;
        if (want.frame_end) n_frames++;
        if (got.pixels !== want.pixels)
          flag_mismatch($sformatf("pixels %h, want %h (line %0d col %0d)",
                                  got.pixels, want.pixels, want.scanline, want.column));
        if (got.column !== want.column)
          flag_mismatch($sformatf("column %0d, want %0d", got.column, want.column));
        if (got.scanline !== want.scanline)
          flag_mismatch($sformatf("scanline %0d, want %0d", got.scanline, want.scanline));
        if (got.line_end !== want.line_end)
          flag_mismatch($sformatf("line_end %b, want %b (line %0d col %0d)",
                                  got.line_end, want.line_end, want.scanline, want.column));
        if (got.frame_end !== want.frame_end)
          flag_mismatch($sformatf("frame_end %b, want %b (line %0d col %0d)",
                                  got.frame_end, want.frame_end, want.scanline, want.column));
      end
    end
  end

  initial begin : stimulus
    dir_row_t dir_tbl [$];
    in_beat_t b;
    int i;
    rst           <= 1'b1;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    row_cnt = 0;
    line_cnt = 0;
    col_cnt = 0;
    row_base = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // fill both memories so no tick ever reads an unwritten byte
    for (i = 0; i < FONT_DEPTH; i++) begin
      b.opcode = OP_FONT_WR;
      b.address = 13'(i);
      b.data = 8'($urandom);
      send_beat(b);
    end
    for (i = 0; i < VRAM_DEPTH; i++) begin
      b.opcode = OP_VRAM_WR;
      b.address = 13'(i);
      b.data = 8'($urandom);
      send_beat(b);
    end

    // directed: top bit of the character dropped, address wrap, unused opcode, first groups
    dir_tbl.push_back(mk_row(OP_VRAM_WR, 13'd0, 8'hc1));
    dir_tbl.push_back(mk_row(OP_FONT_WR, 13'h209, 8'h00));
    dir_tbl.push_back(mk_row(OP_VRAM_WR, 13'd1, 8'h7f));
    dir_tbl.push_back(mk_row(OP_FONT_WR, 13'h3f9, 8'hff));
    dir_tbl.push_back(mk_row(OP_VRAM_WR, 13'd2, 8'h00));
    dir_tbl.push_back(mk_row(OP_FONT_WR, 13'h001, 8'h5a));
    dir_tbl.push_back(mk_row(OP_FONT_WR, 13'h1fff, 8'h3c));
    dir_tbl.push_back(mk_row(OP_VRAM_WR, 13'h1fff, 8'h80));
    dir_tbl.push_back(mk_row(OP_UNUSED, 13'h1fff, 8'hff));
    dir_tbl.push_back(mk_row(OP_TICK, 13'h0000, 8'h00, 1'b1, 8'hff, 6'd0));
    dir_tbl.push_back(mk_row(OP_TICK, 13'h1fff, 8'hff, 1'b1, 8'h00, 6'd1));
    dir_tbl.push_back(mk_row(OP_TICK, 13'h0aaa, 8'h55, 1'b1, 8'ha5, 6'd2));
    dir_tbl.push_back(mk_row(OP_TICK, 13'h1555, 8'haa));
    dir_tbl.push_back(mk_row(OP_TICK, 13'h0000, 8'h00));
    foreach (dir_tbl[k]) send_beat(dir_tbl[k].beat, dir_tbl[k].typed, dir_tbl[k].want);

    sink_quiet = 1'b0;
    src_idle_on = 1'b1;
    run_phase(PHASE_ITEMS);

    // largest sizes, wrap of base and cursor word; sink holds off while ticks keep coming
    configure(64, 64, 32, 8191, 8191, 0, 1);
    src_idle_on = 1'b0;
    hold_req = 1'b1;
    run_phase(60);
    src_idle_on = 1'b1;

    // one column, one row: a frame every ten groups
    configure(1, 1, 1, 0, 0, 65535, 1);
    run_phase(PHASE_ITEMS);

    // zero sizes clamp to one, zero stride gives no scrolling
    configure(0, 0, 0, 4096, 100, CURSOR_BIAS_RST, 1);
    run_phase(PHASE_ITEMS);

    // oversize registers clamp, no scrolling
    configure(127, 127, 63, 8191, 8190, 0, 0);
    run_phase(PHASE_ITEMS);

    // shrink under counters left high by the last setting
    configure(3, 28, 2, 0, CURSOR_LOCATION_RST, CURSOR_BIAS_RST, 1);
    run_phase(PHASE_ITEMS);

    // random settings, mostly small frames so frame ends come often
    for (i = 0; i < 7; i++) begin
      src_idle_on = ($urandom_range(0, 3) != 0);
      sink_quiet = ($urandom_range(0, 3) == 0);
      configure(($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 6),
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64),
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 3),
                $urandom_range(0, 8191), $urandom_range(0, 8191),
                $urandom_range(0, 65535), $urandom_range(0, 1));
      run_phase(PHASE_ITEMS);
    end

    // closing stretch at full rate on both sides
    src_idle_on = 1'b0;
    sink_quiet = 1'b1;
    configure(4, 8, 2, $urandom_range(0, 8191), $urandom_range(0, 8191),
              $urandom_range(0, 65535), 1);
    run_phase(PHASE_ITEMS);

    $display("run covered %0d ticks, %0d memory writes, %0d ignored beats, %0d settings",
             n_ticks, n_writes, n_ignored, n_settings);
    $display("checked %0d pixel groups across %0d frame ends, %0d failures",
             n_checked, n_frames, mismatch_count);
    if (mismatch_count == 0 && pending_groups.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
